### src/fcmc_pkg.sv
// ----------------------------------------------------------------------------
// Field combing metric compare: shared definitions
// Widths, register indexes, plane codes and the control struct that moves
// along the pipeline next to each item.
// ----------------------------------------------------------------------------
package fcmc_pkg;

   // Pixel and field widths.
   localparam int PIX_W    = 8;
   localparam int WIN_W    = 48;
   localparam int PLANE_W  = 2;
   localparam int SCORE_W  = 48;

   // Largest term is 6 * 255 = 1530, so 11 bits; its square needs 22 bits.
   localparam int TERM_W   = 11;
   localparam int SQ_W     = 2 * TERM_W;

   // Default accumulator width.
   localparam int ACC_BITS_DEF = 48;

   // Division by three through a reciprocal: floor(x / 3) = (x * 683) >> 11
   // holds for every x below 2047, and the three-row sum stays below 767.
   localparam int          DIV3_SHIFT = 11;
   localparam logic [10:0] DIV3_RECIP = 11'd683;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_SELECT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUR_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEXT_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SQUARE_MODE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_ORDER    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA_ONLY      = 3'd5;

   // Plane codes; everything that is not luma counts as chroma.
   localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;

   // Metric codes.
   localparam logic METRIC_AVERAGE  = 1'b0;
   localparam logic METRIC_WEIGHTED = 1'b1;

   // Control that travels with an item through the pipeline.
   typedef struct packed {
      logic valid;
      logic active;
      logic last;
   } stage_ctl_type;

endpackage

### src/fcmc_term.sv
// ----------------------------------------------------------------------------
// Field combing metric compare: combing term
// Forms the combing term of five rows of one pixel window and zeroes it
// when it falls below the noise threshold.
// ----------------------------------------------------------------------------
module fcmc_term (
   input  logic [fcmc_pkg::WIN_W-1:0]  window,
   input  logic                        base,
   input  logic [fcmc_pkg::PIX_W-1:0]  threshold,
   input  logic                        metric_select,
   output logic [fcmc_pkg::TERM_W-1:0] term
);
   import fcmc_pkg::*;

   logic [PIX_W-1:0]  px [5];
   logic [9:0]        sum3;
   logic [20:0]       prod3;
   logic [9:0]        sum2;
   logic [8:0]        sum_bd;
   logic [TERM_W-1:0] pos;
   logic [TERM_W-1:0] neg;
   logic [TERM_W-1:0] diff;
   logic [TERM_W-1:0] limit;

   // Pick rows base .. base+4 of the window.
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         px[i] = base ? window[PIX_W*(i+1) +: PIX_W] : window[PIX_W*i +: PIX_W];
      end
   end

   // Averaging metric sums and the division by three.
   assign sum3   = 10'(px[0]) + 10'(px[2]) + 10'(px[4]) + 10'd1;
   assign prod3  = 21'(sum3) * 21'(DIV3_RECIP);
   assign sum_bd = 9'(px[1]) + 9'(px[3]);
   assign sum2   = 10'(sum_bd) + 10'd1;

   // Select the two sides and the limit of the chosen metric.
   always_comb begin
      if (metric_select == METRIC_WEIGHTED) begin
         pos   = TERM_W'(px[0]) + (TERM_W'(px[2]) << 2) + TERM_W'(px[4]);
         neg   = (TERM_W'(sum_bd) << 1) + TERM_W'(sum_bd);
         limit = (TERM_W'(threshold) << 2) + (TERM_W'(threshold) << 1);
      end else begin
         pos   = TERM_W'(prod3[DIV3_SHIFT +: 9]);
         neg   = TERM_W'(sum2[9:1]);
         limit = TERM_W'(threshold);
      end
   end

   // Absolute difference, with terms under the threshold dropped.
   assign diff = (pos >= neg) ? (pos - neg) : (neg - pos);
   assign term = (diff < limit) ? '0 : diff;

endmodule

### src/fcmc_accum.sv
// ----------------------------------------------------------------------------
// Field combing metric compare: score accumulators
// Two saturating accumulators, one for each frame. The totals including
// the item in this stage are shown combinationally; a last item clears
// both accumulators.
// ----------------------------------------------------------------------------
module fcmc_accum #(
   parameter int ACC_BITS = fcmc_pkg::ACC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fcmc_pkg::stage_ctl_type      ctl,
   input  logic                         advance,
   input  logic [fcmc_pkg::SQ_W-1:0]    cur_add,
   input  logic [fcmc_pkg::SQ_W-1:0]    next_add,
   output logic [ACC_BITS-1:0]          cur_total,
   output logic [ACC_BITS-1:0]          next_total
);
   import fcmc_pkg::*;

   logic [ACC_BITS-1:0] cur_acc_ff;
   logic [ACC_BITS-1:0] cur_acc_in;
   logic [ACC_BITS-1:0] next_acc_ff;
   logic [ACC_BITS-1:0] next_acc_in;
   logic                take;

   // Saturating add of one addend into one accumulator.
   function automatic logic [ACC_BITS-1:0] sat_add(
      input logic [ACC_BITS-1:0] acc,
      input logic [SQ_W-1:0]     add,
      input logic                use_add
   );
      logic [ACC_BITS:0] sum;
      sum = {1'b0, acc} + ((ACC_BITS+1)'(add) & {(ACC_BITS+1){use_add}});
      return sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];
   endfunction

   assign take       = ctl.valid && advance;
   assign cur_total  = sat_add(cur_acc_ff, cur_add, ctl.active);
   assign next_total = sat_add(next_acc_ff, next_add, ctl.active);

   // Next accumulator values: hold, add, or clear after a last item.
   always_comb begin
      cur_acc_in  = cur_acc_ff;
      next_acc_in = next_acc_ff;
      if (take) begin
         cur_acc_in  = ctl.last ? '0 : cur_total;
         next_acc_in = ctl.last ? '0 : next_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_acc_ff  <= '0;
         next_acc_ff <= '0;
      end else begin
         cur_acc_ff  <= cur_acc_in;
         next_acc_ff <= next_acc_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Both accumulators start over after a last item.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && ctl.last) |=> (cur_acc_ff == '0 && next_acc_ff == '0))
      else $error("accumulators not cleared after last item");

   // Within a frame pair the scores never go down.
   a_monotonic: assert property (@(posedge clock) disable iff (reset)
      (take && !ctl.last) |=> (cur_acc_ff >= $past(cur_acc_ff) &&
                               next_acc_ff >= $past(next_acc_ff)))
      else $error("accumulator decreased within a frame pair");
`endif

endmodule

### src/field_combing_metric_compare.sv
// A last item accepted into the input register passes the term register and the
// addend register before its result reaches the output register.
// One item per cycle while not held; the accumulator add is the only feedback loop.
// Input stalls only when a last item meets an output register still held by stall.
// Reset clears the configuration registers, both accumulators and all valid flags.
// ----------------------------------------------------------------------------
// Field combing metric compare
// Scores the combing of the current and the candidate next frame over a
// frame pair of pixel windows and reports which frame combs less.
// ----------------------------------------------------------------------------
module field_combing_metric_compare #(
   parameter int ACC_BITS = fcmc_pkg::ACC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input item channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fcmc_pkg::PLANE_W-1:0]     req_plane,
   input  logic [fcmc_pkg::WIN_W-1:0]       req_cur_window,
   input  logic [fcmc_pkg::WIN_W-1:0]       req_next_window,
   input  logic                             req_last,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_choose_next,
   output logic [fcmc_pkg::SCORE_W-1:0]     rsp_cur_score,
   output logic [fcmc_pkg::SCORE_W-1:0]     rsp_next_score,
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fcmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fcmc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fcmc_pkg::*;

   // Configuration registers.
   logic              metric_select_ff;
   logic [PIX_W-1:0]  cur_threshold_ff;
   logic [PIX_W-1:0]  next_threshold_ff;
   logic              square_mode_ff;
   logic              field_order_ff;
   logic              luma_only_ff;

   // Pipeline registers.
   stage_ctl_type     s1_ctl_ff, s1_ctl_in;
   stage_ctl_type     s2_ctl_ff;
   stage_ctl_type     s3_ctl_ff;
   logic [WIN_W-1:0]  s1_cur_win_ff;
   logic [WIN_W-1:0]  s1_next_win_ff;
   logic [TERM_W-1:0] s2_cur_term_ff;
   logic [TERM_W-1:0] s2_next_term_ff;
   logic [SQ_W-1:0]   s3_cur_add_ff;
   logic [SQ_W-1:0]   s3_next_add_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [ACC_BITS-1:0] rsp_cur_ff;
   logic [ACC_BITS-1:0] rsp_next_ff;

   logic [TERM_W-1:0]   cur_term;
   logic [TERM_W-1:0]   next_term;
   logic [ACC_BITS-1:0] cur_total;
   logic [ACC_BITS-1:0] next_total;
   logic                hold;
   logic                advance;
   logic                req_take;
   logic                emit;

   // The pipeline holds only when a last item cannot enter the full output register.
   assign hold      = s3_ctl_ff.valid && s3_ctl_ff.last && rsp_valid_ff && rsp_stall;
   assign advance   = !hold;
   assign req_stall = hold;
   assign req_take  = req_valid && !req_stall;
   assign emit      = s3_ctl_ff.valid && s3_ctl_ff.last && advance;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_select_ff  <= METRIC_AVERAGE;
         cur_threshold_ff  <= '0;
         next_threshold_ff <= '0;
         square_mode_ff    <= 1'b0;
         field_order_ff    <= 1'b0;
         luma_only_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_METRIC_SELECT:  metric_select_ff  <= csr_wdata[0];
            CSR_CUR_THRESHOLD:  cur_threshold_ff  <= csr_wdata;
            CSR_NEXT_THRESHOLD: next_threshold_ff <= csr_wdata;
            CSR_SQUARE_MODE:    square_mode_ff    <= csr_wdata[0];
            CSR_FIELD_ORDER:    field_order_ff    <= csr_wdata[0];
            CSR_LUMA_ONLY:      luma_only_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Input stage control: chroma items under luma-only add nothing.
   always_comb begin
      s1_ctl_in.valid  = req_take;
      s1_ctl_in.active = !(luma_only_ff && req_plane != PLANE_LUMA);
      s1_ctl_in.last   = req_last;
   end

   // Valid flags of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   // Term units; the two frames use opposite row offsets.
   fcmc_term u_cur_term (
      .window        (s1_cur_win_ff),
      .base          (field_order_ff),
      .threshold     (cur_threshold_ff),
      .metric_select (metric_select_ff),
      .term          (cur_term)
   );

   fcmc_term u_next_term (
      .window        (s1_next_win_ff),
      .base          (!field_order_ff),
      .threshold     (next_threshold_ff),
      .metric_select (metric_select_ff),
      .term          (next_term)
   );

   // Payload of the pipeline: windows, terms, then plain or squared addends.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cur_win_ff   <= req_cur_window;
         s1_next_win_ff  <= req_next_window;
         s2_cur_term_ff  <= cur_term;
         s2_next_term_ff <= next_term;
         s3_cur_add_ff   <= square_mode_ff ? SQ_W'(s2_cur_term_ff) * SQ_W'(s2_cur_term_ff)
                                           : SQ_W'(s2_cur_term_ff);
         s3_next_add_ff  <= square_mode_ff ? SQ_W'(s2_next_term_ff) * SQ_W'(s2_next_term_ff)
                                           : SQ_W'(s2_next_term_ff);
      end
   end

   fcmc_accum #(
      .ACC_BITS (ACC_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .ctl        (s3_ctl_ff),
      .advance    (advance),
      .cur_add    (s3_cur_add_ff),
      .next_add   (s3_next_add_ff),
      .cur_total  (cur_total),
      .next_total (next_total)
   );

   // Output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_cur_ff  <= cur_total;
         rsp_next_ff <= next_total;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_choose_next = rsp_next_ff < rsp_cur_ff;

   // Scores are reported at their field width.
   generate
      if (ACC_BITS >= SCORE_W) begin : g_score_trunc
         assign rsp_cur_score  = rsp_cur_ff[SCORE_W-1:0];
         assign rsp_next_score = rsp_next_ff[SCORE_W-1:0];
      end else begin : g_score_ext
         assign rsp_cur_score  = SCORE_W'(rsp_cur_ff);
         assign rsp_next_score = SCORE_W'(rsp_next_ff);
      end
   endgenerate

`ifndef NO_ASSERTIONS
   // Input stalls only behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled without a stalled result");

   // A last item that leaves the accumulator stage always shows a result.
   a_emit_result: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("last item produced no result");

   // A new result appears only from a last item.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result appeared without a last item");
`endif

endmodule
